// ===== design/interpolation_segment_locate_macros.svh =====
// assertion macros for the interpolation segment locate block
`ifndef INTERPOLATION_SEGMENT_LOCATE_MACROS_SVH
`define INTERPOLATION_SEGMENT_LOCATE_MACROS_SVH
`ifndef SYNTH
`define ISL_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ISL_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ISL_ASSERT_IMP(label, clk, rst_n, a, c)
`define ISL_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== design/isl_pkg.sv =====
// shared types and constants for the interpolation segment locate block
package isl_pkg;
  localparam int TableDepth = 1024;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = IdxW + 1;
  localparam int Steps = IdxW;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam logic [0:0] REG_NUM_POINTS = 1'b0;
  localparam logic [0:0] REG_SEGMENT_RANGE = 1'b1;

  typedef struct packed {
    logic              query;
    logic              below;
    logic signed [31:0] x;
    logic [CntW-1:0]   n;
    logic [CntW-1:0]   m;
    logic [IdxW-1:0]   lo;
    logic [IdxW-1:0]   hi;
  } isl_stage_t;
endpackage

// ===== design/isl_if.sv =====
// valid/ready channel interfaces for requests and results
interface isl_in_if;
  import isl_pkg::*;
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [IdxW-1:0]     entry_index;
  logic signed [31:0]  entry_value;
  logic signed [31:0]  query_x;
  modport source (output valid, opcode, entry_index, entry_value, query_x, input ready);
  modport sink (input valid, opcode, entry_index, entry_value, query_x, output ready);
endinterface

interface isl_out_if;
  import isl_pkg::*;
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] start_index;
  logic            in_range;
  modport source (output valid, start_index, in_range, input ready);
  modport sink (input valid, start_index, in_range, output ready);
endinterface

// ===== design/isl_step.sv =====
// one bisection stage with its own copy of the breakpoint table
module isl_step
  import isl_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            wr_en,
  input  logic [IdxW-1:0] wr_addr,
  input  logic [31:0]     wr_data,
  input  logic            in_valid,
  input  isl_stage_t      in_st,
  output logic            mid_valid,
  output logic            out_valid_r,
  output isl_stage_t      out_st_r
);
  logic [31:0] mem [TableDepth];
  logic [IdxW-1:0] mid;
  logic [CntW-1:0] sum;
  logic signed [31:0] rd_r;
  logic            v_r;
  isl_stage_t      st_r;
  isl_stage_t      nxt;

  assign sum = {1'b0, in_st.lo} + {1'b0, in_st.hi};
  assign mid = sum[CntW-1:1];
  assign mid_valid = v_r;

  // read stage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (en) begin
      rd_r <= mem[mid];
      st_r <= in_st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
      out_valid_r <= v_r;
    end
  end

  logic [IdxW-1:0] mid_r;
  logic [CntW-1:0] sum_r;
  assign sum_r = {1'b0, st_r.lo} + {1'b0, st_r.hi};
  assign mid_r = sum_r[CntW-1:1];

  // compare stage
  always_comb begin
    nxt = st_r;
    if (st_r.hi - st_r.lo > IdxW'(1)) begin
      if (st_r.x >= rd_r) nxt.lo = mid_r;
      else nxt.hi = mid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_st_r <= nxt;
    end
  end
endmodule

// ===== design/interpolation_segment_locate.sv =====
// top level: bisection locate of a query in a breakpoint table
//   channel | role   | carries
//   in_     | sink   | load or query request
//   out_    | source | start_index, in_range per query
//   cfg_    | apb    | num_points, segment_range
// a query request can enter every cycle that the output register is not stalled
// a load request waits until no query ahead of it still has table reads to make
// the pipeline advances as a whole unless the output register is full and stalled
// each bisection stage holds its own table copy, all written together by loads
// synchronous active-low reset clears valid bits and registers to 2
module interpolation_segment_locate
  import isl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  isl_in_if.sink      in_ch,
  isl_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:2]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [10:0] num_points_r, segment_range_r;
  logic en;
  logic wr_en;
  logic busy;
  logic [31:0] first_r, last_r;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_points_r <= 11'd2;
      segment_range_r <= 11'd2;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[2])
        REG_NUM_POINTS:    num_points_r <= cfg_pwdata[10:0];
        REG_SEGMENT_RANGE: segment_range_r <= cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end
  assign cfg_prdata = {21'd0, (cfg_paddr[2] == REG_SEGMENT_RANGE) ? segment_range_r
                                                                     : num_points_r};

  // whole pipe stalls only when output register is full and not taken
  assign en = !out_ch.valid || out_ch.ready;
  // a load must not change entries that older queries have yet to read
  assign in_ch.ready = en && !((in_ch.opcode == OP_LOAD) && busy);
  assign wr_en = in_ch.valid && in_ch.ready && (in_ch.opcode == OP_LOAD);

  // effective counts
  logic [CntW-1:0] n_c, m_c;
  always_comb begin
    n_c = num_points_r;
    if (num_points_r < 11'd2) n_c = CntW'(2);
    else if (num_points_r > 11'(TableDepth)) n_c = CntW'(TableDepth);
    m_c = segment_range_r;
    if (segment_range_r < 11'd2) m_c = CntW'(2);
    else if (segment_range_r > n_c) m_c = n_c;
  end

  // bounds fetch stage
  logic [31:0] mem0 [TableDepth];
  logic [31:0] meml [TableDepth];
  logic [IdxW-1:0] last_idx;
  logic [CntW-1:0] nm1;
  logic v0_r, v1_r;
  isl_stage_t s0_r, s1_r;
  isl_stage_t s1_nxt;
  assign nm1 = n_c - CntW'(1);
  assign last_idx = nm1[IdxW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem0[in_ch.entry_index] <= in_ch.entry_value;
      meml[in_ch.entry_index] <= in_ch.entry_value;
    end
    if (en) begin
      first_r <= mem0[0];
      last_r <= meml[last_idx];
      s0_r.query <= 1'b1;
      s0_r.below <= 1'b0;
      s0_r.x <= in_ch.query_x;
      s0_r.n <= n_c;
      s0_r.m <= m_c;
      s0_r.lo <= '0;
      s0_r.hi <= last_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_ch.valid && (in_ch.opcode == OP_QUERY);
      v1_r <= v0_r;
    end
  end

  // range check stage
  always_comb begin
    s1_nxt = s0_r;
    s1_nxt.below = (s0_r.x < $signed(first_r)) || (s0_r.x > $signed(last_r));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

  // bisection chain, one step per stage
  logic       vv [Steps+1];
  isl_stage_t ss [Steps+1];
  logic [Steps-1:0] mid_v;
  assign vv[0] = v1_r;
  assign ss[0] = s1_r;
  for (genvar g = 0; g < Steps; g++) begin : g_step
    isl_step u_step (
      .clk, .rst_n, .en, .wr_en,
      .wr_addr(in_ch.entry_index), .wr_data(in_ch.entry_value),
      .in_valid(vv[g]), .in_st(ss[g]),
      .mid_valid(mid_v[g]),
      .out_valid_r(vv[g+1]), .out_st_r(ss[g+1])
    );
  end

  // any query still ahead of its last table read
  always_comb begin
    busy = v0_r || v1_r;
    for (int i = 0; i < Steps; i++) begin
      busy = busy || vv[i] || mid_v[i];
    end
  end

  // window clamp stage
  isl_stage_t sf;
  logic [CntW-1:0] half, limit, start_a, start_c;
  logic fv_r;
  logic [CntW-1:0] half_r, limit_r;
  logic [IdxW-1:0] lo_r;
  logic out_r_rng;
  assign sf = ss[Steps];
  assign half = (sf.m - CntW'(2)) >> 1;
  assign limit = sf.n - sf.m;

  always_ff @(posedge clk) begin
    if (en) begin
      half_r <= half;
      limit_r <= limit;
      lo_r <= sf.lo;
      out_r_rng <= !sf.below;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) fv_r <= 1'b0;
    else if (en) fv_r <= vv[Steps];
  end

  always_comb begin
    start_a = ({1'b0, lo_r} > half_r) ? {1'b0, lo_r} - half_r : '0;
    start_c = (start_a > limit_r) ? limit_r : start_a;
    if (!out_r_rng) start_c = '0;
  end

  logic out_valid_r;
  logic [IdxW-1:0] start_index_r;
  logic in_range_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= fv_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      start_index_r <= start_c[IdxW-1:0];
      in_range_r <= out_r_rng;
    end
  end
  assign out_ch.valid = out_valid_r;
  assign out_ch.start_index = start_index_r;
  assign out_ch.in_range = in_range_r;

`include "interpolation_segment_locate_macros.svh"
  `ISL_ASSERT_NXT(a_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
  `ISL_ASSERT_IMP(a_rng0, clk, rst_n, out_ch.valid && !out_ch.in_range, out_ch.start_index == '0)
  `ISL_ASSERT_IMP(a_ready, clk, rst_n, !out_ch.valid && !busy, in_ch.ready)
endmodule

// ===== verif/isl_checker.sv =====
// scoreboard for the segment locate block: predicts window start per query and compares
`timescale 1ns / 100ps
module isl_checker
  import isl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  isl_in_if           in_ch,
  isl_out_if          out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:2]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [IdxW-1:0] start_index;
    logic            in_range;
  } window_t;

  window_t            window_q[$];
  logic signed [31:0] breakpoint_tbl[TableDepth];
  logic [CntW-1:0]    num_points_r;
  logic [CntW-1:0]    segment_range_r;
  int                 errs;

  assign fail_count = errs;

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    errs++;
  endtask

  // bisection over the loaded breakpoints, window centred on the bracket
  function automatic window_t locate_window(logic signed [31:0] x);
    window_t w;
    int n, m, lo, hi, mid, half, limit, start;
    n = num_points_r;
    if (n < 2) n = 2;
    if (n > TableDepth) n = TableDepth;
    m = segment_range_r;
    if (m < 2) m = 2;
    if (m > n) m = n;
    if (x < breakpoint_tbl[0] || x > breakpoint_tbl[n-1]) begin
      w.start_index = '0;
      w.in_range = 1'b0;
      return w;
    end
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (x >= breakpoint_tbl[mid]) lo = mid;
      else hi = mid;
    end
    half = (m - 2) / 2;
    limit = n - m;
    start = (lo > half) ? lo - half : 0;
    if (start > limit) start = limit;
    w.start_index = start[IdxW-1:0];
    w.in_range = 1'b1;
    return w;
  endfunction

  initial errs = 0;

  always @(posedge clk) begin
    window_t w;
    if (!rst_n) begin
      num_points_r <= 2;
      segment_range_r <= 2;
      window_q.delete();
      pending <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == REG_NUM_POINTS) num_points_r <= cfg_pwdata[CntW-1:0];
        else segment_range_r <= cfg_pwdata[CntW-1:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.opcode == OP_LOAD) breakpoint_tbl[in_ch.entry_index] = in_ch.entry_value;
        else window_q.push_back(locate_window(in_ch.query_x));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (window_q.size() == 0) begin
          report("result with nothing outstanding, start_index", out_ch.start_index, -1);
        end else begin
          w = window_q.pop_front();
          if (out_ch.start_index !== w.start_index)
            report("start_index", out_ch.start_index, w.start_index);
          if (out_ch.in_range !== w.in_range)
            report("in_range", out_ch.in_range, w.in_range);
        end
      end
      pending <= window_q.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
// testbench top for the segment locate block: stimulus, back-pressure and verdict
`timescale 1ns / 100ps
module tb;
  import isl_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:2]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count;
  int          pending;

  isl_in_if  in_ch();
  isl_out_if out_ch();

  interpolation_segment_locate u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  isl_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .fail_count(fail_count), .pending(pending)
  );

  // 8 ns clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // stimulus-side copy of what has been loaded, used to aim queries at the table
  logic signed [31:0] tbl[TableDepth];
  bit                 written[TableDepth];
  int                 tx_idle;
  int                 rx_idle;
  bit                 rx_hold;
  int                 n_loads;
  int                 n_queries;
  int                 n_settings;
  event               hold_ev;

  // receiver: random ready, forced low during a long hold-off
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle);
  end

  // long receiver hold-off, counted here so the sender keeps offering requests
  initial begin
    rx_hold = 1'b0;
    forever begin
      @(hold_ev);
      rx_hold <= 1'b1;
      repeat (400) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  // one request, with random sender gaps in front of it
  task automatic push(logic op, logic [IdxW-1:0] idx, logic signed [31:0] val,
                      logic signed [31:0] x);
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.entry_index <= idx;
    in_ch.entry_value <= val;
    in_ch.query_x <= x;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == OP_LOAD) begin
      tbl[idx] = val;
      written[idx] = 1'b1;
      n_loads++;
    end else begin
      n_queries++;
    end
  endtask

  task automatic load(int idx, logic signed [31:0] val);
    push(OP_LOAD, idx[IdxW-1:0], val, $urandom);
  endtask

  task automatic query(logic signed [31:0] x);
    push(OP_QUERY, IdxW'($urandom), $urandom, x);
  endtask

  // apb write, setup then access
  task automatic cfg_write(logic [0:0] reg_idx, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= reg_idx;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // let every query come back, then let trailing loads clear the pipeline
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // ascending table, some equal neighbors; or scrambled for the unsorted case
  task automatic fill_table(int n, bit sorted);
    longint v;
    longint step_max;
    step_max = 64'sd2147483648 / n - 1;
    v = -longint'($urandom_range(32'h7fffffff, 0)) - 1;
    for (int i = 0; i < n; i++) begin
      if (!sorted) load(i, $urandom);
      else begin
        load(i, v[31:0]);
        if ($urandom_range(7) != 0) v += longint'($urandom) % (step_max + 1);
      end
    end
  endtask

  // query aimed at entries, between entries, just outside the ends, or anywhere
  function automatic logic signed [31:0] pick_x(int n);
    int  k;
    longint v;
    k = $urandom_range(n - 1);
    case ($urandom_range(7))
      0, 1: v = tbl[k];
      2:    v = longint'(tbl[k]) + $urandom_range(2) - 1;
      3:    v = longint'(tbl[0]) - 1 - $urandom_range(1000);
      4:    v = longint'(tbl[n-1]) + 1 + $urandom_range(1000);
      5:    v = (k < n - 1) ? (longint'(tbl[k]) + longint'(tbl[k+1])) / 2 : tbl[k];
      6:    v = (tbl[n-1] >= tbl[0]) ?
                longint'(tbl[0]) +
                longint'($urandom) % (longint'(tbl[n-1]) - longint'(tbl[0]) + 1) :
                tbl[k];
      default: v = $signed($urandom);
    endcase
    return sat32(v);
  endfunction

  // stray load mixed into the query stream; keeps a sorted table sorted
  task automatic stray_load(int n, bit sorted);
    int idx;
    longint lo_v, hi_v;
    idx = $urandom_range(TableDepth - 1);
    if (idx < n && sorted) begin
      lo_v = (idx > 0) ? tbl[idx-1] : tbl[idx];
      hi_v = (idx < n - 1) ? tbl[idx+1] : tbl[idx];
      load(idx, sat32(lo_v + longint'($urandom) % (hi_v - lo_v + 1)));
    end else if (idx < n) begin
      load(idx, $urandom);
    end else begin
      load(idx, $signed($urandom));
    end
  endtask

  // one register setting: program while idle, make sure the used prefix is written,
  // then a query stream with stray loads; pressure hooks at the halfway point
  task automatic run_phase(int np, int sr, int nq, bit sorted, int pressure);
    int n;
    bit need_fill;
    settle();
    cfg_write(REG_NUM_POINTS, np);
    cfg_write(REG_SEGMENT_RANGE, sr);
    n_settings++;
    n = np & 11'h7ff;
    if (n < 2) n = 2;
    if (n > TableDepth) n = TableDepth;
    need_fill = (n <= 128) || !sorted;
    for (int i = 0; i < n; i++) if (!written[i]) need_fill = 1'b1;
    if (need_fill) fill_table(n, sorted);
    for (int q = 0; q < nq; q++) begin
      if (q == nq / 2 && pressure == 1) -> hold_ev;
      if (q == nq / 2 && pressure == 2) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if ($urandom_range(99) < 15) stray_load(n, sorted);
      else query(pick_x(n));
    end
  endtask

  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("interpolation_segment_locate regression: fail");
    $finish;
  end

  initial begin
    int np;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_LOAD;
    in_ch.entry_index = '0;
    in_ch.entry_value = '0;
    in_ch.query_x = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = REG_NUM_POINTS;
    cfg_pwdata = '0;
    tx_idle = 24;
    rx_idle = 79;
    n_loads = 0;
    n_queries = 0;
    n_settings = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: two-point table at reset settings, value extremes, ends, outside
    load(0, 32'sh80000000);
    load(1, 32'sh7fffffff);
    load(TableDepth - 1, 32'sh7fffffff);
    query(32'sh80000000);
    query(32'sh7fffffff);
    query(32'sh0);
    push(OP_QUERY, '1, '1, 32'sh12345678);
    load(0, 32'sh0);
    load(1, 32'sh64);
    query(-32'sd1);
    query(32'sh65);
    query(32'sh0);
    query(32'sh64);
    query(32'sh32);
    query(32'sh80000000);
    query(32'sh7fffffff);
    // equal neighbors
    load(1, 32'sh0);
    query(32'sh0);
    query(32'sh1);

    // senders slow-ish, receiver mostly stalled
    run_phase(2, 2, 20, 1, 0);
    run_phase(3, 3, 20, 1, 0);
    run_phase(8, 2, 25, 1, 0);
    run_phase(17, 6, 25, 1, 0);
    run_phase(9, 4, 25, 0, 0);
    // roles swapped
    tx_idle = 79;
    rx_idle = 24;
    run_phase(40, 1024, 25, 1, 0);
    run_phase(1024, 1024, 30, 1, 0);
    run_phase(1024, 2, 30, 1, 0);
    run_phase(2047, 517, 30, 1, 0);
    run_phase(0, 0, 20, 1, 0);
    // full rate, with the long receiver hold-off and a full drain pause
    tx_idle = 0;
    rx_idle = 0;
    run_phase(5, 2047, 20, 1, 0);
    run_phase(12, 33, 60, 1, 1);
    run_phase(20, 11, 40, 1, 2);
    for (int p = 0; p < 4; p++) begin
      np = $urandom_range(2, 16);
      run_phase(np, $urandom_range(2047), 10, 1, 0);
    end

    settle();
    $display("ran %0d loads and %0d queries over %0d register settings,",
             n_loads, n_queries, n_settings);
    $display("including clamped counts, equal and unsorted tables and a full-table search");
    if (fail_count == 0 && pending == 0) begin
      $display("interpolation_segment_locate regression: pass");
    end else begin
      $display("interpolation_segment_locate regression: fail");
    end
    $finish;
  end

endmodule
